>>> design/cosim_pkg.sv
// Shared types and constants for the streaming cosine similarity core.
// Used by cosim_ctrl, cosim_dp and cosine_similarity_stream_core.
// No dependencies.
package cosim_pkg;

	localparam int ELEM_W    = 16;
	localparam int MAX_LEN   = 2048;
	localparam int CNT_W     = $clog2(MAX_LEN + 1);
	localparam int DOT_W     = 44;
	localparam int NORM_W    = 43;
	localparam int PP_W      = 2 * ELEM_W;
	localparam int HALF_W    = (NORM_W + 1) / 2;
	localparam int PROD_W    = 2 * NORM_W;
	localparam int M_W       = 62;
	localparam int ROOT_W    = M_W / 2;
	localparam int REM_W     = ROOT_W + 2;
	localparam int E_W       = 7;
	localparam int Q_W       = 15;
	localparam int SH_MAX    = Q_W + (M_W / 2) - 1;
	localparam int NUM_W     = DOT_W + SH_MAX;
	localparam int DV_W      = ROOT_W + Q_W - 1;
	localparam int SIM_W     = 16;
	localparam int STEP_W    = 5;
	localparam int PROD_STEPS = 4;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = Q_W;

	typedef struct packed {
		logic signed [ELEM_W-1:0] elem_a;
		logic signed [ELEM_W-1:0] elem_b;
		logic                     last_elem;
	} in_word_t;

	typedef struct packed {
		logic signed [SIM_W-1:0] similarity;
		logic                    zero_norm;
		logic                    length_overflow;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_FLUSH,
		ST_CHECK,
		ST_PROD,
		ST_NORM,
		ST_SQRT,
		ST_PREP,
		ST_SAT,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       accept;
		logic       clear;
		logic       check;
		logic       prod;
		logic [1:0] prod_idx;
		logic       norm;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       prep;
		logic       sat_chk;
		logic       div_step;
		logic       div_last;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic zero;
		logic norm_done;
		logic sat;
	} dp_sts_t;

endpackage

>>> design/cosim_ctrl.sv
// Sequencer for the cosine similarity core: streaming, then the final
// product / normalize / root / divide steps. Depends on cosim_pkg.
module cosim_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output cosim_pkg::dp_cmd_t  cmd,
	input  cosim_pkg::dp_sts_t  sts
);

	cosim_pkg::state_t               state_q, state_d;
	logic [cosim_pkg::STEP_W-1:0]    step_q;
	logic                            out_valid_q;
	logic                            can_load;

	assign can_load  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == cosim_pkg::ST_ACCUM);

	always_comb begin
		state_d = state_q;
		case (state_q)
			cosim_pkg::ST_ACCUM: begin
				if (in_valid && in_last)
					state_d = cosim_pkg::ST_FLUSH;
			end
			cosim_pkg::ST_FLUSH: state_d = cosim_pkg::ST_CHECK;
			cosim_pkg::ST_CHECK: begin
				state_d = sts.zero ? cosim_pkg::ST_DONE : cosim_pkg::ST_PROD;
			end
			cosim_pkg::ST_PROD: begin
				if (step_q == cosim_pkg::STEP_W'(cosim_pkg::PROD_STEPS - 1))
					state_d = cosim_pkg::ST_NORM;
			end
			cosim_pkg::ST_NORM: begin
				if (sts.norm_done)
					state_d = cosim_pkg::ST_SQRT;
			end
			cosim_pkg::ST_SQRT: begin
				if (step_q == cosim_pkg::STEP_W'(cosim_pkg::SQRT_STEPS - 1))
					state_d = cosim_pkg::ST_PREP;
			end
			cosim_pkg::ST_PREP: state_d = cosim_pkg::ST_SAT;
			cosim_pkg::ST_SAT: begin
				state_d = sts.sat ? cosim_pkg::ST_DONE : cosim_pkg::ST_DIV;
			end
			cosim_pkg::ST_DIV: begin
				if (step_q == cosim_pkg::STEP_W'(cosim_pkg::DIV_STEPS - 1))
					state_d = cosim_pkg::ST_DONE;
			end
			cosim_pkg::ST_DONE: begin
				if (can_load)
					state_d = cosim_pkg::ST_ACCUM;
			end
			default: state_d = cosim_pkg::ST_ACCUM;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			cosim_pkg::ST_ACCUM: cmd.accept = in_valid;
			cosim_pkg::ST_CHECK: cmd.check = 1'b1;
			cosim_pkg::ST_PROD: begin
				cmd.prod     = 1'b1;
				cmd.prod_idx = step_q[1:0];
			end
			cosim_pkg::ST_NORM: begin
				cmd.norm      = !sts.norm_done;
				cmd.sqrt_init = sts.norm_done;
			end
			cosim_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
			cosim_pkg::ST_PREP: cmd.prep = 1'b1;
			cosim_pkg::ST_SAT:  cmd.sat_chk = 1'b1;
			cosim_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_last = (step_q == cosim_pkg::STEP_W'(cosim_pkg::DIV_STEPS - 1));
			end
			cosim_pkg::ST_DONE: begin
				cmd.load_out = can_load;
				cmd.clear    = can_load;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cosim_pkg::ST_ACCUM;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				step_q <= '0;
			else
				step_q <= step_q + 1'b1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> design/cosim_dp.sv
// Datapath of the cosine similarity core: accumulators, norm product,
// normalization, square root, divide and result register. Depends on cosim_pkg.
module cosim_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cosim_pkg::in_word_t  in_data,
	input  cosim_pkg::dp_cmd_t   cmd,
	output cosim_pkg::dp_sts_t   sts,
	output cosim_pkg::out_word_t out_data
);

	logic [cosim_pkg::CNT_W-1:0]     cnt_q;
	logic                            ovf_q;
	logic signed [cosim_pkg::PP_W-1:0] pab_s1, paa_s1, pbb_s1;
	logic                            take_s1;
	logic [cosim_pkg::DOT_W-1:0]     dot_q;
	logic [cosim_pkg::NORM_W-1:0]    na_q, nb_q;
	logic [cosim_pkg::PROD_W-1:0]    prod_q;
	logic signed [cosim_pkg::E_W-1:0] e_q;
	logic [cosim_pkg::M_W-1:0]       sqm_q;
	logic [cosim_pkg::REM_W-1:0]     rem_q;
	logic [cosim_pkg::ROOT_W-1:0]    root_q;
	logic [cosim_pkg::NUM_W-1:0]     num_q;
	logic [cosim_pkg::DV_W-1:0]      dv_q;
	logic [cosim_pkg::Q_W-1:0]       quo_q;
	logic                            neg_q;
	logic signed [cosim_pkg::SIM_W-1:0] res_sim_q;
	logic                            res_zero_q;
	cosim_pkg::out_word_t            out_q;

	logic signed [cosim_pkg::ELEM_W-1:0] ea, eb;
	logic                            take;
	logic [cosim_pkg::HALF_W-1:0]    a_part, b_part;
	logic [2*cosim_pkg::HALF_W-1:0]  pp;
	logic [6:0]                      pp_sh;
	logic                            p_big, p_small;
	logic [cosim_pkg::REM_W+1:0]     r2, trial;
	logic                            r_ge;
	logic [cosim_pkg::DOT_W-1:0]     mag;
	logic [cosim_pkg::E_W-1:0]       sh;
	logic                            d_ge;
	logic [cosim_pkg::Q_W-1:0]       quo_d;

	assign ea   = in_data.elem_a[cosim_pkg::ELEM_W-1:0];
	assign eb   = in_data.elem_b[cosim_pkg::ELEM_W-1:0];
	assign take = (cnt_q < cosim_pkg::CNT_W'(cosim_pkg::MAX_LEN));

	assign a_part = cmd.prod_idx[0] ?
		cosim_pkg::HALF_W'(na_q[cosim_pkg::NORM_W-1:cosim_pkg::HALF_W]) :
		na_q[cosim_pkg::HALF_W-1:0];
	assign b_part = cmd.prod_idx[1] ?
		cosim_pkg::HALF_W'(nb_q[cosim_pkg::NORM_W-1:cosim_pkg::HALF_W]) :
		nb_q[cosim_pkg::HALF_W-1:0];
	assign pp     = a_part * b_part;
	assign pp_sh  = (cmd.prod_idx[0] ? 7'(cosim_pkg::HALF_W) : 7'd0) +
		(cmd.prod_idx[1] ? 7'(cosim_pkg::HALF_W) : 7'd0);

	assign p_big   = |prod_q[cosim_pkg::PROD_W-1:cosim_pkg::M_W];
	assign p_small = !(|prod_q[cosim_pkg::M_W-1:cosim_pkg::M_W-2]);

	assign r2    = {rem_q, sqm_q[cosim_pkg::M_W-1:cosim_pkg::M_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign r_ge  = (r2 >= trial);

	assign mag = dot_q[cosim_pkg::DOT_W-1] ?
		cosim_pkg::DOT_W'(~dot_q + cosim_pkg::DOT_W'(1)) : dot_q;
	assign sh  = cosim_pkg::E_W'(e_q) + cosim_pkg::E_W'(cosim_pkg::Q_W);

	assign d_ge  = (num_q >= cosim_pkg::NUM_W'(dv_q));
	assign quo_d = {quo_q[cosim_pkg::Q_W-2:0], d_ge};

	assign sts.zero      = (na_q == '0) || (nb_q == '0);
	assign sts.norm_done = !p_big && !p_small;
	assign sts.sat       = (num_q >= (cosim_pkg::NUM_W'(root_q) << cosim_pkg::Q_W));
	assign out_data      = out_q;

	// streaming accumulation: product stage, then add stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			take_s1 <= 1'b0;
			dot_q   <= '0;
			na_q    <= '0;
			nb_q    <= '0;
		end else begin
			take_s1 <= cmd.accept && take;
			if (cmd.clear) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				dot_q <= '0;
				na_q  <= '0;
				nb_q  <= '0;
			end else begin
				if (cmd.accept) begin
					if (take)
						cnt_q <= cnt_q + 1'b1;
					else
						ovf_q <= 1'b1;
				end
				if (take_s1) begin
					dot_q <= dot_q + cosim_pkg::DOT_W'(pab_s1);
					na_q  <= na_q + cosim_pkg::NORM_W'(paa_s1);
					nb_q  <= nb_q + cosim_pkg::NORM_W'(pbb_s1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pab_s1 <= ea * eb;
		paa_s1 <= ea * ea;
		pbb_s1 <= eb * eb;
	end

	// final evaluation and result register
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			res_zero_q <= sts.zero;
			res_sim_q  <= '0;
		end
		if (cmd.prod) begin
			prod_q <= ((cmd.prod_idx == 2'd0) ? '0 : prod_q) +
				(cosim_pkg::PROD_W'(pp) << pp_sh);
			if (cmd.prod_idx == 2'd0)
				e_q <= '0;
		end
		if (cmd.norm) begin
			if (p_big) begin
				prod_q <= prod_q >> 2;
				e_q    <= e_q - 1'b1;
			end else if (p_small) begin
				prod_q <= prod_q << 2;
				e_q    <= e_q + 1'b1;
			end
		end
		if (cmd.sqrt_init) begin
			sqm_q  <= prod_q[cosim_pkg::M_W-1:0];
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			sqm_q <= sqm_q << 2;
			if (r_ge) begin
				rem_q  <= cosim_pkg::REM_W'(r2 - trial);
				root_q <= {root_q[cosim_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= r2[cosim_pkg::REM_W-1:0];
				root_q <= {root_q[cosim_pkg::ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.prep) begin
			neg_q <= dot_q[cosim_pkg::DOT_W-1];
			num_q <= (cosim_pkg::NUM_W'(mag) << sh) +
				cosim_pkg::NUM_W'(root_q >> 1);
		end
		if (cmd.sat_chk) begin
			dv_q  <= cosim_pkg::DV_W'(root_q) << (cosim_pkg::Q_W - 1);
			quo_q <= '0;
			if (sts.sat)
				res_sim_q <= neg_q ? {1'b1, {(cosim_pkg::SIM_W-1){1'b0}}} :
					{1'b0, {(cosim_pkg::SIM_W-1){1'b1}}};
		end
		if (cmd.div_step) begin
			if (d_ge)
				num_q <= num_q - cosim_pkg::NUM_W'(dv_q);
			dv_q  <= dv_q >> 1;
			quo_q <= quo_d;
			if (cmd.div_last)
				res_sim_q <= neg_q ?
					cosim_pkg::SIM_W'(-{1'b0, quo_d}) :
					cosim_pkg::SIM_W'({1'b0, quo_d});
		end
		if (cmd.load_out) begin
			out_q.similarity      <= res_sim_q;
			out_q.zero_norm       <= res_zero_q;
			out_q.length_overflow <= ovf_q;
		end
	end

endmodule

>>> design/cosine_similarity_stream_core.sv
// Top level of the streaming cosine similarity core.
// Depends on cosim_pkg, cosim_ctrl and cosim_dp.
//
// Element pairs are taken one per cycle while a vector streams in. After the
// pair marked last the core stops taking words and evaluates the result:
// it drains the product stage, checks for a zero norm, builds the norm
// product from 22x22 partial products, normalizes it with two-bit shifts,
// takes its bit-pair square root, sets up and checks saturation, runs the
// restoring divide (skipped on saturation) for a 15-bit quotient and loads
// the output; a zero norm goes straight from the check to the output load.
// The result sits in an output register, so the next vector can stream in
// while it waits to be taken.
module cosine_similarity_stream_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cosim_pkg::in_word_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cosim_pkg::out_word_t out_data
);

	cosim_pkg::dp_cmd_t cmd;
	cosim_pkg::dp_sts_t sts;

	cosim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_data.last_elem),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	cosim_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
